// File: design/router_packet_classifier_dedup_top_defines.svh
// Assertion macros used by the top level of the router packet classifier.
`ifndef ROUTER_PACKET_CLASSIFIER_DEDUP_TOP_DEFINES_SVH
`define ROUTER_PACKET_CLASSIFIER_DEDUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPCD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rpcd_pkg.sv
// Package with the types, constants and codes of the router packet classifier.
package rpcd_pkg;

   localparam int SEEN_ENTRIES = 64;
   localparam int SEEN_IDX_W   = $clog2(SEEN_ENTRIES);
   localparam int SEEN_CNT_W   = $clog2(SEEN_ENTRIES + 1);
   localparam int KEY_W        = 48;

   localparam int LOCAL_NUM    = 4;
   localparam int LOCAL_IDX_W  = 2;
   localparam int LOCAL_CNT_W  = 3;

   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 152;
   localparam int RSP_DATA_W   = 24;
   localparam int ACTION_W     = 3;

   localparam logic [31:0] BCAST_ADDR   = 32'hffff_ffff;
   localparam logic [15:0] EXPIRE_RESET = 16'd500;

   localparam logic OPC_CLASSIFY  = 1'b0;
   localparam logic OPC_ORIGINATE = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DELIVER    = 3'd0,
      ACT_DROP       = 3'd1,
      ACT_RELAY      = 3'd2,
      ACT_RELAY_LS   = 3'd3,
      ACT_FORWARD    = 3'd4,
      ACT_ORIGINATED = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      REG_LOCAL_ADDR_0     = 3'd0,
      REG_LOCAL_ADDR_1     = 3'd1,
      REG_LOCAL_ADDR_2     = 3'd2,
      REG_LOCAL_ADDR_3     = 3'd3,
      REG_LOCAL_COUNT      = 3'd4,
      REG_EXPIRE_WINDOW    = 3'd5,
      REG_CONTROL_PROTOCOL = 3'd6,
      REG_LINKSTATE_TYPE   = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [LOCAL_NUM-1:0][31:0] local_addr;
      logic [LOCAL_CNT_W-1:0]     local_count;
      logic [15:0]                expire_window;
      logic [7:0]                 control_protocol;
      logic [31:0]                linkstate_type;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] packet_id;
      logic [7:0]  protocol;
      logic [31:0] payload_type;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic load;
      logic classify;
      logic scan_rd;
      logic scan_cmp;
      logic commit;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_orig;
      logic is_local;
      logic is_bcast;
      logic scan_end;
      logic match;
      logic dup;
      logic out_free;
   } dpath_sts_type;

endpackage

// File: design/router_packet_classifier_dedup_top.sv
// Top level of the router packet classifier with broadcast duplicate suppression.
//
// A header transaction enters on req_* and exactly one result transaction leaves on rsp_*.
// The configuration registers sit on the csr_* port; the user must write them only while
// the block is idle, and the block itself does not enforce this. One item is worked on at
// a time. A delivered or forwarded item goes from classification straight to its result.
// A broadcast or an originate searches the seen table entry by entry through its single
// memory port, with a read state and a compare state for each entry. The search covers up
// to the fill count of entries (64 when the table is full) and ends at the first match: a
// dropped duplicate then goes straight to its result, any other outcome through the table
// update. The scan of the seen table sets the rate for broadcasts.
// The block returns to idle as the result is loaded into the output register,
// so a waiting result does not hold back the next acceptance.
// If the receiver stalls, the finished result stays in the output register; a following
// item is worked up to its result and then waits until that register is free.
// Reset is synchronous and active high: the table becomes empty, and the id counter,
// replacement pointer, state, configuration and output valid flag reset; other datapath
// registers do not. No clearing pass is needed after reset: a fill count marks used entries.
module router_packet_classifier_dedup_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // opcode
   input  logic [0:0]                         req_tuser,
   // src_addr, dst_addr, packet_id, protocol, payload_type, now_ms
   input  logic [rpcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // action
   output logic [rpcd_pkg::ACTION_W-1:0]      rsp_tuser,
   // local_port, broadcast_id
   output logic [rpcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rpcd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rpcd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpcd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import rpcd_pkg::*;
   `include "router_packet_classifier_dedup_top_defines.svh"

   cfg_type                cfg;
   item_type               req_item;
   ctrl_cmd_type           cmd;
   dpath_sts_type          sts;
   logic [LOCAL_IDX_W-1:0] rsp_port;
   logic [15:0]            rsp_bid;

   assign req_item.opcode       = req_tuser[0];
   assign req_item.src_addr     = req_tdata[31:0];
   assign req_item.dst_addr     = req_tdata[63:32];
   assign req_item.packet_id    = req_tdata[79:64];
   assign req_item.protocol     = req_tdata[87:80];
   assign req_item.payload_type = req_tdata[119:88];
   assign req_item.now_ms       = req_tdata[151:120];

   assign rsp_tdata = {6'd0, rsp_bid, rsp_port};

   rpcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rpcd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_action (rsp_tuser),
      .rsp_port   (rsp_port),
      .rsp_bid    (rsp_bid)
   );

   `RPCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
                     !req_tready, "ready high right after an accepted transaction")
   `RPCD_ASSERT_IMPLY(a_bid_only_originate, clock, reset,
                      rsp_tvalid && (rsp_tuser != ACT_ORIGINATED), rsp_bid == 16'd0,
                      "broadcast id set on a non-originate result")
   `RPCD_ASSERT_IMPLY(a_port_only_deliver, clock, reset,
                      rsp_tvalid && (rsp_tuser != ACT_DELIVER), rsp_port == '0,
                      "local port set on a non-deliver result")

endmodule

// File: design/rpcd_csr.sv
// Configuration register file of the router packet classifier with its APB-style port.
module rpcd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rpcd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rpcd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpcd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output rpcd_pkg::cfg_type              cfg
);
   import rpcd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LOCAL_ADDR_0:     cfg_in.local_addr[0] = csr_pwdata;
            REG_LOCAL_ADDR_1:     cfg_in.local_addr[1] = csr_pwdata;
            REG_LOCAL_ADDR_2:     cfg_in.local_addr[2] = csr_pwdata;
            REG_LOCAL_ADDR_3:     cfg_in.local_addr[3] = csr_pwdata;
            REG_LOCAL_COUNT:      cfg_in.local_count = csr_pwdata[LOCAL_CNT_W-1:0];
            REG_EXPIRE_WINDOW:    cfg_in.expire_window = csr_pwdata[15:0];
            REG_CONTROL_PROTOCOL: cfg_in.control_protocol = csr_pwdata[7:0];
            REG_LINKSTATE_TYPE:   cfg_in.linkstate_type = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LOCAL_ADDR_0:     csr_prdata = cfg_ff.local_addr[0];
         REG_LOCAL_ADDR_1:     csr_prdata = cfg_ff.local_addr[1];
         REG_LOCAL_ADDR_2:     csr_prdata = cfg_ff.local_addr[2];
         REG_LOCAL_ADDR_3:     csr_prdata = cfg_ff.local_addr[3];
         REG_LOCAL_COUNT:      csr_prdata = {{(CSR_DATA_W-LOCAL_CNT_W){1'b0}},
                                             cfg_ff.local_count};
         REG_EXPIRE_WINDOW:    csr_prdata = {16'd0, cfg_ff.expire_window};
         REG_CONTROL_PROTOCOL: csr_prdata = {24'd0, cfg_ff.control_protocol};
         REG_LINKSTATE_TYPE:   csr_prdata = cfg_ff.linkstate_type;
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{local_addr: '0, local_count: '0, expire_window: EXPIRE_RESET,
                     control_protocol: '0, linkstate_type: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/rpcd_ctrl.sv
// Controller state machine that sequences classification, table scan and update.
module rpcd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rpcd_pkg::dpath_sts_type sts,
   output rpcd_pkg::ctrl_cmd_type  cmd
);
   import rpcd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CLASSIFY = 6'b000010,
      ST_SCAN_RD  = 6'b000100,
      ST_SCAN_CMP = 6'b001000,
      ST_COMMIT   = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            if (sts.is_orig || (!sts.is_local && sts.is_bcast)) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (sts.match) begin
               state_in = (!sts.is_orig && sts.dup) ? ST_DONE : ST_COMMIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/rpcd_dpath.sv
// Datapath with the header registers, the seen table memory and the result register.
module rpcd_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  rpcd_pkg::cfg_type                 cfg,
   input  rpcd_pkg::item_type                req_item,
   input  rpcd_pkg::ctrl_cmd_type            cmd,
   output rpcd_pkg::dpath_sts_type           sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rpcd_pkg::ACTION_W-1:0]     rsp_action,
   output logic [rpcd_pkg::LOCAL_IDX_W-1:0]  rsp_port,
   output logic [15:0]                       rsp_bid
);
   import rpcd_pkg::*;

   logic [KEY_W-1:0] key_mem [SEEN_ENTRIES];
   logic [31:0]      time_mem [SEEN_ENTRIES];

   item_type               item_ff;
   logic [KEY_W-1:0]       rd_key_ff;
   logic [31:0]            rd_time_ff;
   logic [SEEN_CNT_W-1:0]  idx_ff, idx_in;
   logic [SEEN_CNT_W-1:0]  fill_ff, fill_in;
   logic [SEEN_IDX_W-1:0]  rptr_ff, rptr_in;
   logic [15:0]            next_id_ff, next_id_in;
   logic                   found_ff, found_in;
   action_type             action_ff, action_in;
   logic [LOCAL_IDX_W-1:0] port_ff, port_in;
   logic [15:0]            bid_ff, bid_in;
   logic                   out_valid_ff, out_valid_in;
   action_type             out_action_ff;
   logic [LOCAL_IDX_W-1:0] out_port_ff;
   logic [15:0]            out_bid_ff;

   logic [LOCAL_CNT_W-1:0] local_n;
   logic                   local_hit;
   logic [LOCAL_IDX_W-1:0] local_port;
   logic [KEY_W-1:0]       key;
   logic [31:0]            age;
   logic                   is_ls;
   logic                   table_full;
   logic [SEEN_IDX_W-1:0]  wr_slot;

   assign local_n = (cfg.local_count > LOCAL_CNT_W'(LOCAL_NUM)) ?
                    LOCAL_CNT_W'(LOCAL_NUM) : cfg.local_count;

   always_comb begin
      local_hit  = 1'b0;
      local_port = '0;
      for (int i = 0; i < LOCAL_NUM; i++) begin
         if ((LOCAL_CNT_W'(i) < local_n) && (item_ff.dst_addr == cfg.local_addr[i])) begin
            local_hit  = 1'b1;
            local_port = LOCAL_IDX_W'(i);
         end
      end
   end

   assign key        = (item_ff.opcode == OPC_ORIGINATE) ? {cfg.local_addr[0], bid_ff} :
                       {item_ff.src_addr, item_ff.packet_id};
   assign age        = item_ff.now_ms - rd_time_ff;
   assign is_ls      = (item_ff.protocol == cfg.control_protocol) &&
                       (item_ff.payload_type == cfg.linkstate_type);
   assign table_full = (fill_ff == SEEN_CNT_W'(SEEN_ENTRIES));
   assign wr_slot    = found_ff   ? idx_ff[SEEN_IDX_W-1:0] :
                       table_full ? rptr_ff : fill_ff[SEEN_IDX_W-1:0];

   assign sts.is_orig  = (item_ff.opcode == OPC_ORIGINATE);
   assign sts.is_local = local_hit;
   assign sts.is_bcast = (item_ff.dst_addr == BCAST_ADDR);
   assign sts.scan_end = (idx_ff == fill_ff);
   assign sts.match    = (rd_key_ff == key);
   assign sts.dup      = (age <= {16'd0, cfg.expire_window});
   assign sts.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rptr_in      = rptr_ff;
      next_id_in   = next_id_ff;
      found_in     = found_ff;
      action_in    = action_ff;
      port_in      = port_ff;
      bid_in       = bid_ff;
      out_valid_in = out_valid_ff;
      if (cmd.classify) begin
         idx_in   = '0;
         found_in = 1'b0;
         port_in  = '0;
         bid_in   = '0;
         if (item_ff.opcode == OPC_ORIGINATE) begin
            next_id_in = next_id_ff + 16'd1;
            bid_in     = next_id_ff + 16'd1;
            action_in  = ACT_ORIGINATED;
         end else if (local_hit) begin
            port_in   = local_port;
            action_in = ACT_DELIVER;
         end else begin
            action_in = ACT_FORWARD;
         end
      end
      if (cmd.scan_cmp) begin
         if (sts.match) begin
            found_in = 1'b1;
            if (!sts.is_orig && sts.dup) begin
               action_in = ACT_DROP;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (cmd.commit) begin
         if (!found_ff) begin
            if (table_full) begin
               rptr_in = (rptr_ff == SEEN_IDX_W'(SEEN_ENTRIES - 1)) ? '0 : rptr_ff + 1'b1;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         if (!sts.is_orig) begin
            action_in = is_ls ? ACT_RELAY_LS : ACT_RELAY;
         end
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rptr_ff      <= '0;
         next_id_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rptr_ff      <= rptr_in;
         next_id_ff   <= next_id_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      action_ff <= action_in;
      port_ff   <= port_in;
      bid_ff    <= bid_in;
      if (cmd.emit) begin
         out_action_ff <= action_ff;
         out_port_ff   <= port_ff;
         out_bid_ff    <= bid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_key_ff  <= key_mem[idx_ff[SEEN_IDX_W-1:0]];
         rd_time_ff <= time_mem[idx_ff[SEEN_IDX_W-1:0]];
      end
      if (cmd.commit) begin
         key_mem[wr_slot]  <= key;
         time_mem[wr_slot] <= item_ff.now_ms;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;
   assign rsp_port   = out_port_ff;
   assign rsp_bid    = out_bid_ff;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the router packet classifier with broadcast duplicate suppression.
`timescale 1ns / 100ps

module tb;
   import rpcd_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 116;

   typedef struct packed {
      action_type  action;
      logic [1:0]  port;
      logic [15:0] bid;
   } verdict_type;

   typedef struct {
      bit          is_csr;
      csr_reg_type csr_reg;
      logic [31:0] csr_value;
      item_type    hdr;
      bit          typed;
      verdict_type verdict;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // opcode
   logic [0:0]            req_tuser;
   // src_addr, dst_addr, packet_id, protocol, payload_type, now_ms
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // action
   logic [ACTION_W-1:0]   rsp_tuser;
   // local_port, broadcast_id
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   verdict_type    pending_verdicts[$];
   script_row_type script[$];
   int             error_count = 0;
   int             stalled_cycles = 0;
   bit             steady_flow = 1'b0;

   logic [KEY_W-1:0]      seen_key_m[SEEN_ENTRIES];
   logic [31:0]           seen_time_m[SEEN_ENTRIES];
   bit                    seen_valid_m[SEEN_ENTRIES];
   logic [SEEN_IDX_W-1:0] repl_ptr_m;
   logic [15:0]           bcast_id_m;
   logic [31:0]           loc_addr_m[LOCAL_NUM];
   logic [2:0]            loc_count_m;
   logic [15:0]           window_m;
   logic [7:0]            ctrl_proto_m;
   logic [31:0]           ls_type_m;

   router_packet_classifier_dedup_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(0, 99) < 20);
   endfunction

   function automatic int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < SEEN_ENTRIES; i++)
         if (seen_valid_m[i] && seen_key_m[i] == key) return i;
      return -1;
   endfunction

   function automatic void record_key(logic [KEY_W-1:0] key, logic [31:0] now);
      int slot;
      slot = find_slot(key);
      if (slot < 0) begin
         for (int i = SEEN_ENTRIES - 1; i >= 0; i--)
            if (!seen_valid_m[i]) slot = i;
         if (slot < 0) begin
            slot = int'(repl_ptr_m);
            repl_ptr_m = repl_ptr_m + 1'b1;
         end
      end
      seen_key_m[slot] = key;
      seen_time_m[slot] = now;
      seen_valid_m[slot] = 1'b1;
   endfunction

   function automatic verdict_type classify_header(item_type hdr);
      verdict_type v;
      int          n;
      int          slot;
      bit          hit;
      logic [31:0] age;
      v.action = ACT_FORWARD;
      v.port = 2'd0;
      v.bid = 16'd0;
      if (hdr.opcode == OPC_ORIGINATE) begin
         bcast_id_m = bcast_id_m + 16'd1;
         v.bid = bcast_id_m;
         record_key({loc_addr_m[0], bcast_id_m}, hdr.now_ms);
         v.action = ACT_ORIGINATED;
      end else begin
         n = (loc_count_m > 3'd4) ? LOCAL_NUM : int'(loc_count_m);
         hit = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (hdr.dst_addr == loc_addr_m[i]) begin
               hit = 1'b1;
               v.port = i[1:0];
            end
         end
         if (hit) begin
            v.action = ACT_DELIVER;
         end else if (hdr.dst_addr == BCAST_ADDR) begin
            slot = find_slot({hdr.src_addr, hdr.packet_id});
            age = 32'd0;
            if (slot >= 0) age = hdr.now_ms - seen_time_m[slot];
            if (slot >= 0 && age <= {16'd0, window_m}) begin
               v.action = ACT_DROP;
            end else begin
               record_key({hdr.src_addr, hdr.packet_id}, hdr.now_ms);
               v.action = (hdr.protocol == ctrl_proto_m && hdr.payload_type == ls_type_m) ?
                          ACT_RELAY_LS : ACT_RELAY;
            end
         end
      end
      return v;
   endfunction

   task automatic send_header(input item_type hdr, input bit typed, input verdict_type fixed);
      verdict_type v;
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= hdr.opcode;
      req_tdata <= {hdr.now_ms, hdr.payload_type, hdr.protocol, hdr.packet_id,
                    hdr.dst_addr, hdr.src_addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      v = classify_header(hdr);
      pending_verdicts.push_back(typed ? fixed : v);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_LOCAL_ADDR_0:     loc_addr_m[0] = value;
         REG_LOCAL_ADDR_1:     loc_addr_m[1] = value;
         REG_LOCAL_ADDR_2:     loc_addr_m[2] = value;
         REG_LOCAL_ADDR_3:     loc_addr_m[3] = value;
         REG_LOCAL_COUNT:      loc_count_m = value[2:0];
         REG_EXPIRE_WINDOW:    window_m = value[15:0];
         REG_CONTROL_PROTOCOL: ctrl_proto_m = value[7:0];
         REG_LINKSTATE_TYPE:   ls_type_m = value;
         default: ;
      endcase
   endtask

   task automatic add_cfg(input csr_reg_type idx, input logic [31:0] value);
      script_row_type row;
      row.is_csr = 1'b1;
      row.csr_reg = idx;
      row.csr_value = value;
      row.typed = 1'b0;
      script.push_back(row);
   endtask

   task automatic add_hdr(input logic op, input logic [31:0] src, input logic [31:0] dst,
                          input logic [15:0] pid, input logic [7:0] proto,
                          input logic [31:0] ptype, input logic [31:0] now, input bit typed,
                          input action_type act, input logic [1:0] port,
                          input logic [15:0] bid);
      script_row_type row;
      row.is_csr = 1'b0;
      row.hdr.opcode = op;
      row.hdr.src_addr = src;
      row.hdr.dst_addr = dst;
      row.hdr.packet_id = pid;
      row.hdr.protocol = proto;
      row.hdr.payload_type = ptype;
      row.hdr.now_ms = now;
      row.typed = typed;
      row.verdict.action = act;
      row.verdict.port = port;
      row.verdict.bid = bid;
      script.push_back(row);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stalled_cycles <= 0;
      end else begin
         rsp_tready <= !take_gap();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stalled_cycles <= 0;
         else stalled_cycles <= stalled_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected result transaction, action %0d", rsp_tuser);
               error_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_tuser != want.action) begin
                  $error("action: expected %0d, actual %0d", want.action, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[1:0] != want.port) begin
                  $error("local_port: expected %0d, actual %0d", want.port, rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[17:2] != want.bid) begin
                  $error("broadcast_id: expected %0d, actual %0d", want.bid, rsp_tdata[17:2]);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("router_packet_classifier_dedup_top regression: fail");
      $finish;
   end

   initial begin
      item_type       hdr;
      verdict_type    v;
      script_row_type row;
      logic [31:0]    cfg_vals[8];
      logic [31:0]    src_pool[8];
      logic [31:0]    cur_ms;
      int             pick;
      int             sub;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      for (int i = 0; i < SEEN_ENTRIES; i++) seen_valid_m[i] = 1'b0;
      repl_ptr_m = '0;
      bcast_id_m = 16'd0;
      for (int i = 0; i < LOCAL_NUM; i++) loc_addr_m[i] = 32'd0;
      loc_count_m = 3'd0;
      window_m = EXPIRE_RESET;
      ctrl_proto_m = 8'd0;
      ls_type_m = 32'd0;
      v = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_hdr(OPC_CLASSIFY, 32'h0, 32'h0, 16'h0, 8'h0, 32'h0, 32'h0,
              1'b1, ACT_FORWARD, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'hffffffff, BCAST_ADDR, 16'hffff, 8'h0, 32'h0, 32'd0,
              1'b1, ACT_RELAY_LS, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'hffffffff, BCAST_ADDR, 16'hffff, 8'h0, 32'h0, 32'd500,
              1'b1, ACT_DROP, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'hffffffff, BCAST_ADDR, 16'hffff, 8'h0, 32'h0, 32'd1001,
              1'b1, ACT_RELAY_LS, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'hffffffff, BCAST_ADDR, 16'hffff, 8'h0, 32'h0, 32'd1000,
              1'b1, ACT_RELAY_LS, 2'd0, 16'd0);
      add_hdr(OPC_ORIGINATE, 32'hffffffff, 32'hffffffff, 16'hffff, 8'hff, 32'hffffffff,
              32'hffffffff, 1'b1, ACT_ORIGINATED, 2'd0, 16'd1);
      add_hdr(OPC_CLASSIFY, 32'h0, BCAST_ADDR, 16'd1, 8'h7, 32'h5, 32'd499,
              1'b1, ACT_DROP, 2'd0, 16'd0);
      add_cfg(REG_LOCAL_ADDR_0, 32'h0a000001);
      add_cfg(REG_LOCAL_ADDR_1, BCAST_ADDR);
      add_cfg(REG_LOCAL_ADDR_2, 32'h0a000001);
      add_cfg(REG_LOCAL_ADDR_3, 32'hc0a80001);
      add_cfg(REG_LOCAL_COUNT, 32'd7);
      add_cfg(REG_EXPIRE_WINDOW, 32'd0);
      add_cfg(REG_CONTROL_PROTOCOL, 32'hff);
      add_cfg(REG_LINKSTATE_TYPE, 32'hffffffff);
      add_hdr(OPC_CLASSIFY, 32'h1, 32'h0a000001, 16'h0, 8'h0, 32'h0, 32'd0,
              1'b1, ACT_DELIVER, 2'd2, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h1, BCAST_ADDR, 16'h0, 8'hff, 32'hffffffff, 32'd0,
              1'b1, ACT_DELIVER, 2'd1, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h1, 32'hc0a80001, 16'h0, 8'h0, 32'h0, 32'd0,
              1'b1, ACT_DELIVER, 2'd3, 16'd0);
      add_cfg(REG_LOCAL_COUNT, 32'd2);
      add_hdr(OPC_CLASSIFY, 32'h1, 32'hc0a80001, 16'h0, 8'h0, 32'h0, 32'd0,
              1'b1, ACT_FORWARD, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h1, BCAST_ADDR, 16'h0, 8'h0, 32'h0, 32'd0,
              1'b1, ACT_DELIVER, 2'd1, 16'd0);
      add_cfg(REG_LOCAL_COUNT, 32'd0);
      add_hdr(OPC_CLASSIFY, 32'h0a000001, BCAST_ADDR, 16'd2, 8'hff, 32'hffffffff, 32'd100,
              1'b1, ACT_RELAY_LS, 2'd0, 16'd0);
      add_hdr(OPC_ORIGINATE, 32'h0, 32'h0, 16'h0, 8'h0, 32'h0, 32'd100,
              1'b1, ACT_ORIGINATED, 2'd0, 16'd2);
      add_hdr(OPC_CLASSIFY, 32'h0a000001, BCAST_ADDR, 16'd2, 8'hff, 32'hffffffff, 32'd100,
              1'b1, ACT_DROP, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h0a000001, BCAST_ADDR, 16'd2, 8'hff, 32'hffffffff, 32'd101,
              1'b1, ACT_RELAY_LS, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h1, BCAST_ADDR, 16'd0, 8'hff, 32'h0, 32'd5,
              1'b1, ACT_RELAY, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h2, BCAST_ADDR, 16'd0, 8'hfe, 32'hffffffff, 32'd5,
              1'b1, ACT_RELAY, 2'd0, 16'd0);
      add_cfg(REG_EXPIRE_WINDOW, 32'hffff);
      add_hdr(OPC_CLASSIFY, 32'h1, BCAST_ADDR, 16'd0, 8'hff, 32'h0, 32'd65540,
              1'b1, ACT_DROP, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h1, BCAST_ADDR, 16'd0, 8'hff, 32'h0, 32'd65541,
              1'b1, ACT_RELAY, 2'd0, 16'd0);
      add_hdr(OPC_ORIGINATE, $urandom, $urandom, 16'($urandom), 8'($urandom), $urandom,
              32'd70000, 1'b0, ACT_FORWARD, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, $urandom, $urandom, 16'($urandom), 8'($urandom), $urandom,
              $urandom, 1'b0, ACT_FORWARD, 2'd0, 16'd0);
      add_hdr(OPC_CLASSIFY, 32'h0a000001, BCAST_ADDR, 16'd3, 8'h11, 32'h0, 32'd70001,
              1'b0, ACT_FORWARD, 2'd0, 16'd0);

      foreach (script[i]) begin
         row = script[i];
         if (row.is_csr) begin
            wait_idle();
            csr_write(row.csr_reg, row.csr_value);
         end else begin
            send_header(row.hdr, row.typed, row.verdict);
         end
      end

      src_pool[0] = 32'h0;
      src_pool[1] = 32'hffffffff;
      for (int i = 2; i < 8; i++) src_pool[i] = $urandom;
      cur_ms = $urandom;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         for (int r = 0; r < LOCAL_NUM; r++) cfg_vals[r] = $urandom;
         if (phase == 1) cfg_vals[REG_LOCAL_ADDR_1] = BCAST_ADDR;
         if (phase == 2) cfg_vals[REG_LOCAL_ADDR_2] = 32'd0;
         if (phase % 3 == 0) cfg_vals[REG_LOCAL_ADDR_3] = cfg_vals[REG_LOCAL_ADDR_0];
         cfg_vals[REG_LOCAL_COUNT] = phase;
         cfg_vals[REG_EXPIRE_WINDOW] = (phase == 0) ? 32'd0 :
                                       (phase == 1) ? 32'hffff :
                                       (phase == 2) ? 32'(EXPIRE_RESET) :
                                       $urandom_range(0, 3000);
         cfg_vals[REG_CONTROL_PROTOCOL] = (phase == 4) ? 32'd0 :
                                          (phase % 2 == 1) ? 32'hff : $urandom_range(0, 255);
         cfg_vals[REG_LINKSTATE_TYPE] = (phase == 0) ? 32'd0 :
                                        (phase == 1) ? 32'hffffffff : $urandom;
         for (int r = 0; r < 8; r++) csr_write(csr_reg_type'(r), cfg_vals[r]);
         steady_flow = (phase == 5);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS / 2) wait_idle();
            if ($urandom_range(0, 99) < 85)
               cur_ms = cur_ms + $urandom_range(0, 2 * int'(window_m) + 2);
            else
               cur_ms = cur_ms + $urandom;
            hdr.opcode = OPC_CLASSIFY;
            hdr.src_addr = $urandom;
            hdr.dst_addr = $urandom;
            hdr.packet_id = 16'($urandom);
            hdr.protocol = 8'($urandom);
            hdr.payload_type = $urandom;
            hdr.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : cur_ms;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               hdr.opcode = OPC_ORIGINATE;
            end else if (pick < 25) begin
               hdr.dst_addr = loc_addr_m[$urandom_range(0, LOCAL_NUM - 1)];
            end else if (pick < 75) begin
               hdr.dst_addr = BCAST_ADDR;
               sub = $urandom_range(0, 99);
               if (sub < 55) begin
                  hdr.src_addr = src_pool[$urandom_range(0, 7)];
                  hdr.packet_id = 16'($urandom_range(0, 7));
               end else if (sub < 70) begin
                  hdr.src_addr = loc_addr_m[0];
                  hdr.packet_id = bcast_id_m + 16'($urandom_range(0, 3));
               end
               if ($urandom_range(0, 1)) hdr.protocol = ctrl_proto_m;
               if ($urandom_range(0, 1)) hdr.payload_type = ls_type_m;
            end
            send_header(hdr, 1'b0, v);
         end
      end

      wait_idle();
      steady_flow = 1'b0;
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0)
         $display("router_packet_classifier_dedup_top regression: pass");
      else
         $display("router_packet_classifier_dedup_top regression: fail");
      $finish;
   end

endmodule
